// ===== hdl/wcd_pkg.sv =====
// shared types, constants and crc function for the wavelet container deframer
package wcd_pkg;

    localparam int TrailerBytes = 4;
    localparam int PrefixLen = 18;
    localparam int QueueDepth = 4;
    localparam int QueueAw = $clog2(QueueDepth);

    localparam logic [7:0] MagicP = 8'h50;
    localparam logic [7:0] MagicR = 8'h52;
    localparam logic [7:0] MagicS = 8'h53;
    localparam logic [7:0] MagicM = 8'h4D;
    localparam logic [7:0] VersionOne = 8'h01;

    localparam logic [31:0] CrcPoly = 32'hEDB88320;
    localparam logic [31:0] CrcInit = 32'hFFFFFFFF;

    typedef enum logic [2:0] {
        KIND_HEADER  = 3'd0,
        KIND_PLANE   = 3'd1,
        KIND_SUBBAND = 3'd2,
        KIND_PAYLOAD = 3'd3,
        KIND_END     = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_MAGIC     = 3'd2,
        ST_VERSION   = 3'd3,
        ST_FLAG      = 3'd4,
        ST_TRUNCATED = 3'd5,
        ST_CRC       = 3'd6
    } status_t;

    typedef enum logic [3:0] {
        PH_PREFIX  = 4'd0,
        PH_WHDR    = 4'd1,
        PH_PLANES  = 4'd2,
        PH_NSUB    = 4'd3,
        PH_SUB     = 4'd4,
        PH_PAYLOAD = 4'd5,
        PH_DRAIN   = 4'd6
    } phase_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  record_kind;
        logic [7:0]  filter_or_orient;
        logic [7:0]  level_value;
        logic [7:0]  max_bit_planes;
        logic [7:0]  resid_mode;
        logic [7:0]  plane_count;
        logic [31:0] count_word;
        logic [15:0] span_x;
        logic [15:0] span_y;
        logic [7:0]  data_byte;
        logic [2:0]  status;
        logic        out_last;
    } out_item_t;

    // classified work handed from front to back
    typedef struct packed {
        logic      has_rec;
        out_item_t rec;
        logic      has_end;
        logic [2:0] end_status;
    } work_t;

    // queue fill status
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // bytewise reflected crc-32 update
    function automatic logic [31:0] crc_update(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== hdl/wcd_front.sv =====
// front part: parses the container and builds record work items
module wcd_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [7:0]        flag_mask,
    input  logic              in_valid,
    output logic              in_ready,
    input  wcd_pkg::in_item_t in_item,
    output logic              w_valid,
    output wcd_pkg::work_t    w_item,
    input  wcd_pkg::q_stat_t  q_stat
);

    wcd_pkg::phase_t phase_reg, phase_next;
    logic [4:0]  pos_reg, pos_next;
    logic [31:0] acc_reg, acc_next;
    logic [63:0] hdr_reg, hdr_next;
    logic [7:0]  planes_reg, planes_next;
    logic [15:0] subs_reg, subs_next;
    logic [47:0] sub_reg, sub_next;
    logic [7:0]  dly_reg [wcd_pkg::TrailerBytes];
    logic [7:0]  dly_next [wcd_pkg::TrailerBytes];
    logic [2:0]  fill_reg, fill_next;
    logic [31:0] crc_reg, crc_next;
    logic [2:0]  err_reg, err_next;

    logic [7:0] b;
    logic       fire;

    assign b        = in_item.in_byte;
    assign in_ready = !q_stat.full;
    assign fire     = in_valid && in_ready;
    assign w_valid  = fire;

    // parse step
    always_comb begin
        logic [31:0] stored;
        logic [7:0]  crc_in;
        phase_next = phase_reg;
        pos_next = pos_reg;
        acc_next = acc_reg;
        hdr_next = hdr_reg;
        planes_next = planes_reg;
        subs_next = subs_reg;
        sub_next = sub_reg;
        dly_next = dly_reg;
        fill_next = fill_reg;
        err_next = err_reg;
        crc_in = (phase_reg == wcd_pkg::PH_PAYLOAD) ? dly_reg[0] : b;
        crc_next = crc_reg;
        if (phase_reg != wcd_pkg::PH_DRAIN
            && !(phase_reg == wcd_pkg::PH_PAYLOAD && fill_reg < 3'(wcd_pkg::TrailerBytes))) begin
            crc_next = wcd_pkg::crc_update(crc_reg, crc_in);
        end
        w_item = '0;
        unique case (phase_reg)
            wcd_pkg::PH_PREFIX: begin
                if (err_reg == 3'd0) begin
                    priority if ((pos_reg == 5'd0 && b != wcd_pkg::MagicP)
                                 || (pos_reg == 5'd1 && b != wcd_pkg::MagicR)
                                 || (pos_reg == 5'd2 && b != wcd_pkg::MagicS)
                                 || (pos_reg == 5'd3 && b != wcd_pkg::MagicM)) begin
                        err_next = wcd_pkg::ST_MAGIC;
                    end else if (pos_reg == 5'd4 && b != wcd_pkg::VersionOne) begin
                        err_next = wcd_pkg::ST_VERSION;
                    end else if (pos_reg == 5'd16 && (b & flag_mask) == 8'd0) begin
                        err_next = wcd_pkg::ST_FLAG;
                    end else begin
                    end
                end
                pos_next = pos_reg + 5'd1;
                if (pos_reg == 5'(wcd_pkg::PrefixLen - 1)) begin
                    pos_next = '0;
                    phase_next = (err_next != 3'd0) ? wcd_pkg::PH_DRAIN : wcd_pkg::PH_WHDR;
                end
            end
            wcd_pkg::PH_WHDR: begin
                if (pos_reg < 5'd8) begin
                    hdr_next[pos_reg[2:0]*8 +: 8] = b;
                    pos_next = pos_reg + 5'd1;
                end else if (pos_reg < 5'd10) begin
                    acc_next[pos_reg[0]*8 +: 8] = b;
                    pos_next = pos_reg + 5'd1;
                end else begin
                    w_item.has_rec = 1'b1;
                    w_item.rec.record_kind = wcd_pkg::KIND_HEADER;
                    w_item.rec.filter_or_orient = hdr_reg[7:0];
                    w_item.rec.level_value = hdr_reg[15:8];
                    w_item.rec.max_bit_planes = hdr_reg[23:16];
                    w_item.rec.resid_mode = hdr_reg[31:24];
                    w_item.rec.plane_count = b;
                    w_item.rec.count_word = hdr_reg[63:32];
                    w_item.rec.span_x = acc_reg[15:0];
                    planes_next = b;
                    hdr_next = '0;
                    acc_next = '0;
                    pos_next = '0;
                    phase_next = (b != 8'd0) ? wcd_pkg::PH_PLANES : wcd_pkg::PH_NSUB;
                end
            end
            wcd_pkg::PH_PLANES: begin
                acc_next[pos_reg[1:0]*8 +: 8] = b;
                if (pos_reg >= 5'd3) begin
                    w_item.has_rec = 1'b1;
                    w_item.rec.record_kind = wcd_pkg::KIND_PLANE;
                    w_item.rec.count_word = acc_next;
                    acc_next = '0;
                    pos_next = '0;
                    planes_next = planes_reg - 8'd1;
                    if (planes_reg == 8'd1) phase_next = wcd_pkg::PH_NSUB;
                end else begin
                    pos_next = pos_reg + 5'd1;
                end
            end
            wcd_pkg::PH_NSUB: begin
                acc_next[pos_reg[0]*8 +: 8] = b;
                if (pos_reg >= 5'd1) begin
                    subs_next = acc_next[15:0];
                    pos_next = '0;
                    acc_next = '0;
                    phase_next = (acc_next[15:0] != 16'd0) ? wcd_pkg::PH_SUB
                                                           : wcd_pkg::PH_PAYLOAD;
                    if ({b, acc_reg[7:0]} != 16'd0) phase_next = wcd_pkg::PH_SUB;
                    else phase_next = wcd_pkg::PH_PAYLOAD;
                    subs_next = {b, acc_reg[7:0]};
                end else begin
                    pos_next = pos_reg + 5'd1;
                end
            end
            wcd_pkg::PH_SUB: begin
                if (pos_reg < 5'd6) begin
                    sub_next[pos_reg[2:0]*8 +: 8] = b;
                    pos_next = pos_reg + 5'd1;
                end else if (pos_reg == 5'd6) begin
                    hdr_next = {56'd0, b};
                    pos_next = pos_reg + 5'd1;
                end else begin
                    acc_next[2'(pos_reg - 5'd7)*8 +: 8] = b;
                    if (pos_reg >= 5'd10) begin
                        w_item.has_rec = 1'b1;
                        w_item.rec.record_kind = wcd_pkg::KIND_SUBBAND;
                        w_item.rec.filter_or_orient = sub_reg[7:0];
                        w_item.rec.level_value = sub_reg[15:8];
                        w_item.rec.max_bit_planes = hdr_reg[7:0];
                        w_item.rec.count_word = acc_next;
                        w_item.rec.span_x = sub_reg[31:16];
                        w_item.rec.span_y = sub_reg[47:32];
                        sub_next = '0;
                        hdr_next = '0;
                        acc_next = '0;
                        pos_next = '0;
                        subs_next = subs_reg - 16'd1;
                        if (subs_reg == 16'd1) phase_next = wcd_pkg::PH_PAYLOAD;
                    end else begin
                        pos_next = pos_reg + 5'd1;
                    end
                end
            end
            wcd_pkg::PH_PAYLOAD: begin
                if (fill_reg >= 3'(wcd_pkg::TrailerBytes)) begin
                    w_item.has_rec = 1'b1;
                    w_item.rec.record_kind = wcd_pkg::KIND_PAYLOAD;
                    w_item.rec.data_byte = dly_reg[0];
                    for (int k = 0; k < wcd_pkg::TrailerBytes - 1; k++) begin
                        dly_next[k] = dly_reg[k + 1];
                    end
                    dly_next[wcd_pkg::TrailerBytes - 1] = b;
                end else begin
                    dly_next[fill_reg[1:0]] = b;
                    fill_next = fill_reg + 3'd1;
                end
            end
            default: begin
            end
        endcase

        // end of frame status
        stored = '0;
        for (int k = 0; k < wcd_pkg::TrailerBytes; k++) begin
            stored[k*8 +: 8] = dly_next[k];
        end
        w_item.has_end = in_item.in_last;
        priority if (phase_next == wcd_pkg::PH_PREFIX) begin
            w_item.end_status = wcd_pkg::ST_SHORT;
        end else if (err_next != 3'd0) begin
            w_item.end_status = err_next;
        end else if (phase_next != wcd_pkg::PH_PAYLOAD
                     || fill_next < 3'(wcd_pkg::TrailerBytes)) begin
            w_item.end_status = wcd_pkg::ST_TRUNCATED;
        end else begin
            w_item.end_status = (stored == ~crc_next) ? wcd_pkg::ST_OK : wcd_pkg::ST_CRC;
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn || (fire && in_item.in_last)) begin
            phase_reg <= wcd_pkg::PH_PREFIX;
            pos_reg <= '0;
            acc_reg <= '0;
            hdr_reg <= '0;
            planes_reg <= '0;
            subs_reg <= '0;
            sub_reg <= '0;
            for (int k = 0; k < wcd_pkg::TrailerBytes; k++) dly_reg[k] <= '0;
            fill_reg <= '0;
            crc_reg <= wcd_pkg::CrcInit;
            err_reg <= '0;
        end else if (fire) begin
            phase_reg <= phase_next;
            pos_reg <= pos_next;
            acc_reg <= acc_next;
            hdr_reg <= hdr_next;
            planes_reg <= planes_next;
            subs_reg <= subs_next;
            sub_reg <= sub_next;
            dly_reg <= dly_next;
            fill_reg <= fill_next;
            crc_reg <= crc_next;
            err_reg <= err_next;
        end
    end

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= 3'(wcd_pkg::TrailerBytes)) else $error("delay fill overrun");
    a_payload_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && w_item.has_rec && w_item.rec.record_kind == wcd_pkg::KIND_PAYLOAD)
        |-> fill_reg == 3'(wcd_pkg::TrailerBytes)) else $error("payload before fill");
    a_drain_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == wcd_pkg::PH_DRAIN) |-> !w_item.has_rec) else $error("drain record");

endmodule

// ===== hdl/wcd_queue.sv =====
// short work queue between front and back
module wcd_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_en,
    input  wcd_pkg::work_t   wr_item,
    output wcd_pkg::q_stat_t q_stat,
    input  logic             rd_en,
    output wcd_pkg::work_t   rd_item
);

    wcd_pkg::work_t mem_reg [wcd_pkg::QueueDepth];
    logic [wcd_pkg::QueueAw-1:0] wp_reg, rp_reg;
    logic [wcd_pkg::QueueAw:0]   cnt_reg;

    assign q_stat.full  = cnt_reg == (wcd_pkg::QueueAw+1)'(wcd_pkg::QueueDepth);
    assign q_stat.empty = cnt_reg == '0;
    assign rd_item = mem_reg[rp_reg];

    // storage
    always_ff @(posedge aclk) begin
        if (wr_en) mem_reg[wp_reg] <= wr_item;
    end

    // pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (wr_en) wp_reg <= wp_reg + 1'b1;
            if (rd_en) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (wcd_pkg::QueueAw+1)'(wr_en) - (wcd_pkg::QueueAw+1)'(rd_en);
        end
    end

    a_no_over: assert property (@(posedge aclk) disable iff (!aresetn)
        q_stat.full |-> !wr_en) else $error("queue overflow");
    a_no_under: assert property (@(posedge aclk) disable iff (!aresetn)
        q_stat.empty |-> !rd_en) else $error("queue underflow");
    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_en && !rd_en) |=> cnt_reg == $past(cnt_reg) + 1'b1) else $error("count slip");

endmodule

// ===== hdl/wcd_back.sv =====
// back part: emits up to two records per work item into an output register
module wcd_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  wcd_pkg::q_stat_t   q_stat,
    input  wcd_pkg::work_t     q_item,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output wcd_pkg::out_item_t m_item
);

    logic               vld_reg;
    wcd_pkg::out_item_t out_reg;
    logic               done_rec_reg;   // record half of head item already sent
    logic               load;
    logic               need_end;
    wcd_pkg::out_item_t end_rec;

    assign m_valid = vld_reg;
    assign m_item  = out_reg;
    assign load    = !vld_reg || m_ready;

    // end record of the head item
    always_comb begin
        end_rec = '0;
        end_rec.record_kind = wcd_pkg::KIND_END;
        end_rec.status = q_item.end_status;
        end_rec.out_last = 1'b1;
    end

    assign need_end = q_item.has_end;
    // pop once the last record of the head item is loaded
    assign q_pop = load && !q_stat.empty
                   && (!(q_item.has_rec && !done_rec_reg) || !need_end);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
            done_rec_reg <= 1'b0;
        end else if (load) begin
            vld_reg <= 1'b0;
            if (!q_stat.empty) begin
                if (q_item.has_rec && !done_rec_reg) begin
                    vld_reg <= 1'b1;
                    out_reg <= q_item.rec;
                    done_rec_reg <= need_end;
                end else if (need_end) begin
                    vld_reg <= 1'b1;
                    out_reg <= end_rec;
                    done_rec_reg <= 1'b0;
                end
            end
        end
    end

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid && $stable(m_item)) else $error("output moved");
    a_done_end: assert property (@(posedge aclk) disable iff (!aresetn)
        done_rec_reg |-> (!q_stat.empty && q_item.has_end)) else $error("split lost");
    a_last_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_item.out_last) |-> m_item.record_kind == wcd_pkg::KIND_END)
        else $error("last on non end");

endmodule

// ===== hdl/wavelet_container_deframer_unit.sv =====
// top level of the wavelet container deframer
// Usage: container bytes enter on s_valid/s_ready with s_item (byte and
// last flag); records leave on m_valid/m_ready with m_item. flag_mask is
// written through cfg_valid/cfg_ready/cfg_data; the user must write it
// only while the block is idle, and the block does not enforce it. Each
// accepted byte is parsed by the front part, which updates the bytewise
// crc-32 and pushes one work transaction into a four-entry queue. The
// back part turns a work transaction into at most two records (a record
// and an end record on the last byte) through an output register. One
// byte is accepted per cycle while the queue is not full; a byte that
// yields a record and an end record has them loaded in turn. A record
// goes through the queue into the output register and shows on m_valid.
// The four trailing bytes are held in a delay line, so payload records lag
// their bytes by four bytes; the crc is checked at the last byte.
// Reset (aresetn low, synchronous) clears the parser, the queue and the
// output register, and sets flag_mask to 1. When the receiver stalls the
// output holds, the queue fills and s_ready drops once it is full.
module wavelet_container_deframer_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  wcd_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output wcd_pkg::out_item_t m_item
);

    logic [7:0]       flag_mask_reg;
    logic             w_valid;
    wcd_pkg::work_t   w_item;
    wcd_pkg::work_t   q_item;
    wcd_pkg::q_stat_t q_stat;
    logic             q_pop;

    assign cfg_ready = 1'b1;

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) flag_mask_reg <= 8'd1;
        else if (cfg_valid) flag_mask_reg <= cfg_data;
    end

    wcd_front u_front (
        .aclk(aclk), .aresetn(aresetn), .flag_mask(flag_mask_reg),
        .in_valid(s_valid), .in_ready(s_ready), .in_item(s_item),
        .w_valid(w_valid), .w_item(w_item), .q_stat(q_stat)
    );

    wcd_queue u_queue (
        .aclk(aclk), .aresetn(aresetn), .wr_en(w_valid), .wr_item(w_item),
        .q_stat(q_stat), .rd_en(q_pop), .rd_item(q_item)
    );

    wcd_back u_back (
        .aclk(aclk), .aresetn(aresetn), .q_stat(q_stat), .q_item(q_item),
        .q_pop(q_pop), .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item)
    );

endmodule
